// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the checker files of this block.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent, and reports a failure through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPTB_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sptb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPTB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sptb assertion failed");

`endif

// ----- rtl/sptb_pkg.sv -----
`default_nettype none

package sptb_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_SLOTS_DEF   = 16;
    localparam int PERIOD_BITS_DEF = 32;

    // Field widths of the command and result beats.
    localparam int CMD_W      = 2;
    localparam int TICK_W     = 20;
    localparam int SLOT_W     = 4;
    localparam int INTERVAL_W = 32;
    localparam int MASK_W     = 16;
    localparam int TOTAL_W    = 64;

    // Speed is unsigned Q8.
    localparam int SPEED_W    = 12;
    localparam int SPEED_FRAC = 8;
    localparam int STEP_W     = TICK_W + SPEED_W - SPEED_FRAC;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSED = 2'd1;

    localparam logic [SPEED_W-1:0] SPEED_MIN   = 12'd26;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 12'd2560;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd256;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;

    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [MASK_W-1:0]  mask_t;

endpackage

`default_nettype wire

// ----- rtl/sptb_slot_ram.sv -----
`default_nettype none

// Simple dual-port slot memory: one write port, one read port with
// registered read data.
module sptb_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 65,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/scaled_periodic_timer_bank_top.sv -----
`default_nettype none

// Bank of NUM_SLOTS periodic timer slots in two classes, real-time and game-time,
// driven by a stream of command beats (tick, register slot, remove slot), each of
// which returns exactly one result beat carrying the fired mask, both time totals
// and a status bit. Slot periods and counts live in a single slot memory with one
// write and one registered read port; the valid and class bits of the slots sit in
// flip-flops so that a register or remove finishes in the cycle it is accepted.
// A tick passes through a scale state for the speed multiply, then a three-stage
// read, add and saturate, compare and write-back pipeline that walks the slot
// memory one slot per cycle, then a finish state that hands the result to the
// output register once that register is free. A register, remove or unused
// command goes straight from acceptance to the finish state. The next command
// is taken once the finish state has handed its result on. The block works
// on one command at a time; a new command is taken while an earlier
// result still waits in the output register. Configuration writes are always
// ready and should only be issued while no command is in flight.
module scaled_periodic_timer_bank_top #(
    parameter int NUM_SLOTS   = sptb_pkg::NUM_SLOTS_DEF,
    parameter int PERIOD_BITS = sptb_pkg::PERIOD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [sptb_pkg::CMD_W-1:0]      cmd,
    input  wire logic [sptb_pkg::TICK_W-1:0]     tick_us,
    input  wire logic [sptb_pkg::SLOT_W-1:0]     slot,
    input  wire logic [sptb_pkg::INTERVAL_W-1:0] interval_us,
    input  wire logic                            realtime_req,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [sptb_pkg::MASK_W-1:0]     fired_mask,
    output logic      [sptb_pkg::TOTAL_W-1:0]    game_time_us,
    output logic      [sptb_pkg::TOTAL_W-1:0]    real_time_us,
    output logic                                 status,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sptb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sptb_pkg::CFG_DATA_W-1:0] cfg_data
);

    import sptb_pkg::*;

    localparam int AW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W   = $clog2(NUM_SLOTS + 2);
    localparam int CW      = PERIOD_BITS + 1;
    localparam int SUM_W   = ((CW > STEP_W) ? CW : STEP_W) + 1;
    localparam int ENTRY_W = PERIOD_BITS + CW;
    localparam int PROD_W  = TICK_W + SPEED_W;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(NUM_SLOTS);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(NUM_SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCALE  = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Clamp a speed write into the 0.1 to 10 range.
    function automatic logic [SPEED_W-1:0] sat_speed(input logic [CFG_DATA_W-1:0] v);
        logic [SPEED_W-1:0] r;
        r = SPEED_W'(v);
        if (r < SPEED_MIN)
        begin
            r = SPEED_MIN;
        end
        else if (r > SPEED_MAX)
        begin
            r = SPEED_MAX;
        end
        return r;
    endfunction

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [SPEED_W-1:0]   speed_reg;
    logic                 paused_reg;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] rt_reg;
    logic [TICK_W-1:0]    tick_reg;
    logic [STEP_W-1:0]    scaled_reg;
    total_t               game_total_reg;
    total_t               real_total_reg;
    logic [CNT_W-1:0]     cnt_reg;

    // Sweep pipeline: stage 1 holds the slot whose memory word is arriving,
    // stage 2 holds the saturated count waiting for compare and write-back.
    logic                 p1_vld_reg;
    logic [AW-1:0]        p1_idx_reg;
    logic                 p2_vld_reg;
    logic [AW-1:0]        p2_idx_reg;
    logic [CW-1:0]        p2_cnt_reg;
    logic [PERIOD_BITS-1:0] p2_per_reg;

    mask_t                mask_reg;
    logic                 status_reg;
    logic                 out_valid_reg;
    mask_t                out_mask_reg;
    total_t               out_game_reg;
    total_t               out_real_reg;
    logic                 out_status_reg;

    logic                 in_accept;
    logic                 slot_in_range;
    logic [AW-1:0]        slot_addr;
    logic                 slot_used;
    logic                 reg_ok;
    logic                 rm_hit;
    logic                 rd_go;
    logic                 out_free;
    logic [PROD_W-1:0]    product;

    logic [ENTRY_W-1:0]   ram_rdata;
    logic [PERIOD_BITS-1:0] rd_per;
    logic [CW-1:0]        rd_cnt;
    logic                 slot_rt;
    logic                 active;
    logic [STEP_W-1:0]    step;
    logic [SUM_W-1:0]     sum;
    logic [CW-1:0]        sat_cnt;
    logic                 fire;
    logic [CW-1:0]        new_cnt;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;

    // Command side.
    assign in_stall      = (state_reg != ST_IDLE);
    assign in_accept     = in_valid && (state_reg == ST_IDLE);
    assign slot_in_range = (32'(slot) < NUM_SLOTS);
    assign slot_addr     = AW'(slot);
    assign slot_used     = slot_in_range && valid_reg[slot_addr];
    assign reg_ok        = in_accept && (cmd == CMD_REGISTER) && slot_in_range
                           && !valid_reg[slot_addr];
    assign rm_hit        = in_accept && (cmd == CMD_REMOVE) && slot_in_range;
    assign out_free      = !out_valid_reg || !out_stall;

    assign cfg_ready = 1'b1;

    // Speed multiply, 20 x 12 bits, used in the scale cycle.
    assign product = PROD_W'(tick_reg) * PROD_W'(speed_reg);

    // Sweep stage 0: issue the read of the next slot.
    assign rd_go = (state_reg == ST_SWEEP) && (cnt_reg < SLOTS_CNT);

    // Sweep stage 1: add the step and saturate the count.
    assign rd_per  = ram_rdata[ENTRY_W-1:CW];
    assign rd_cnt  = ram_rdata[CW-1:0];
    assign slot_rt = rt_reg[p1_idx_reg];
    assign active  = p1_vld_reg && valid_reg[p1_idx_reg] && (slot_rt || !paused_reg);
    assign step    = slot_rt ? STEP_W'(tick_reg) : scaled_reg;
    assign sum     = SUM_W'(rd_cnt) + SUM_W'(step);
    assign sat_cnt = (|sum[SUM_W-1:CW]) ? {CW{1'b1}} : sum[CW-1:0];

    // Sweep stage 2: compare against the period and subtract once.
    assign fire    = p2_cnt_reg > CW'(p2_per_reg);
    assign new_cnt = fire ? (p2_cnt_reg - CW'(p2_per_reg)) : p2_cnt_reg;

    // The sweep write-back and a register command never share a cycle.
    always_comb
    begin
        if (p2_vld_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = p2_idx_reg;
            ram_wdata = {p2_per_reg, new_cnt};
        end
        else
        begin
            ram_we    = reg_ok;
            ram_waddr = slot_addr;
            ram_wdata = {PERIOD_BITS'(interval_us), CW'(0)};
        end
    end

    sptb_slot_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (ENTRY_W),
        .AW    (AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_go ? cnt_reg[AW-1:0] : AW'(0)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (cmd == CMD_TICK) ? ST_SCALE : ST_FINISH;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, slot flags, totals and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            speed_reg      <= SPEED_RESET;
            paused_reg     <= 1'b0;
            valid_reg      <= '0;
            rt_reg         <= '0;
            game_total_reg <= '0;
            real_total_reg <= '0;
            cnt_reg        <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            p1_vld_reg <= rd_go;
            p2_vld_reg <= active;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SPEED:  speed_reg  <= sat_speed(cfg_data);
                    CFG_PAUSED: paused_reg <= cfg_data[0];
                    default:    ;
                endcase
            end

            if (reg_ok)
            begin
                valid_reg[slot_addr] <= 1'b1;
                rt_reg[slot_addr]    <= realtime_req;
            end
            if (rm_hit)
            begin
                valid_reg[slot_addr] <= 1'b0;
            end

            if (state_reg == ST_SCALE)
            begin
                real_total_reg <= real_total_reg + TOTAL_W'(tick_reg);
            end

            if (state_reg == ST_SWEEP)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                // The scaled step is ready from the first sweep cycle on.
                if ((cnt_reg == '0) && !paused_reg)
                begin
                    game_total_reg <= game_total_reg + TOTAL_W'(scaled_reg);
                end
            end
            else
            begin
                cnt_reg <= '0;
            end

            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tick_reg   <= tick_us;
            mask_reg   <= '0;
            status_reg <= (cmd == CMD_REGISTER) && (!slot_in_range || slot_used);
        end
        else if (p2_vld_reg && fire)
        begin
            mask_reg <= mask_reg | (MASK_W'(1) << p2_idx_reg);
        end

        if (state_reg == ST_SCALE)
        begin
            scaled_reg <= product[PROD_W-1:SPEED_FRAC];
        end

        p1_idx_reg <= cnt_reg[AW-1:0];
        p2_idx_reg <= p1_idx_reg;
        p2_cnt_reg <= sat_cnt;
        p2_per_reg <= rd_per;

        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_mask_reg   <= mask_reg;
            out_game_reg   <= game_total_reg;
            out_real_reg   <= real_total_reg;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fired_mask   = out_mask_reg;
    assign game_time_us = out_game_reg;
    assign real_time_us = out_real_reg;
    assign status       = out_status_reg;

endmodule

`default_nettype wire

// ----- rtl/sptb_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module sptb_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [sptb_pkg::MASK_W-1:0] fired_mask,
    input wire logic [sptb_pkg::TOTAL_W-1:0] real_time_us,
    input wire logic                        status
);

    // One command at a time: the block is busy right after taking a beat.
    `SPTB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // A rejected register never reports fired slots.
    `SPTB_ASSERT_NOW(a_reject_no_fire, clk, rst_n, out_valid && status, fired_mask == '0)

    // A stalled result stays valid and unchanged.
    `SPTB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `SPTB_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(fired_mask) && $stable(real_time_us) && $stable(status))

endmodule

bind scaled_periodic_timer_bank_top sptb_checker u_sptb_checker (.*);

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

// Self-checking bench for the scaled periodic timer bank.
//
// Every command beat that the block accepts is run through a local model of
// the slot bank at the moment of acceptance. That model keeps its own copy
// of the slot flags, periods and counts, the two time totals and the speed
// and pause settings. The predicted result beat goes onto a queue, and the
// monitor compares each result beat that leaves the block against the oldest
// entry there, field by field.
//
// Stimulus runs in phases. A short directed list comes first, under the reset
// settings. Then each phase writes new speed and pause values while the bank
// is idle and queues a batch of random commands. One phase runs the game clock
// at full speed for long enough that a zero-period slot count climbs to its
// ceiling and saturates. Both the sender and the receiver insert random gaps.
// Once, the receiver holds off for a long stretch while commands are still
// queued, so the block backs up and stalls its command input.
module testbench;
    import sptb_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;

    // Command code 3 is not assigned; the block must treat it as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // The configuration index field has room for two unused registers.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int NUM_PHASES     = 7;
    localparam int SATURATE_PHASE = 5;
    localparam int PHASE_ITEMS    = 80;
    localparam int SATURATE_ITEMS = 920;
    localparam int HOLD_CYCLES    = 600;

    // Slot counts carry one bit more than the period and saturate at all ones.
    localparam logic [INTERVAL_W:0] COUNT_CEILING = '1;

    typedef struct packed {
        logic [CMD_W-1:0]      op;
        logic [TICK_W-1:0]     us;
        logic [SLOT_W-1:0]     idx;
        logic [INTERVAL_W-1:0] period;
        logic                  rt;
    } timer_cmd_t;

    typedef struct packed {
        mask_t  mask;
        total_t game;
        total_t wall;
        logic   rejected;
    } timer_result_t;

    // Clock and reset. Reset is released at a falling edge, away from the
    // edge at which the block samples.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // Command channel.
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      cmd          = CMD_TICK;
    logic [TICK_W-1:0]     tick_us      = '0;
    logic [SLOT_W-1:0]     slot         = '0;
    logic [INTERVAL_W-1:0] interval_us  = '0;
    logic                  realtime_req = 1'b0;

    // Result channel.
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    mask_t                 fired_mask;
    total_t                game_time_us;
    total_t                real_time_us;
    logic                  status;

    // Configuration channel.
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_SPEED;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    scaled_periodic_timer_bank_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .tick_us      (tick_us),
        .slot         (slot),
        .interval_us  (interval_us),
        .realtime_req (realtime_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fired_mask   (fired_mask),
        .game_time_us (game_time_us),
        .real_time_us (real_time_us),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Local copy of the slot bank, advanced once per accepted command beat.
    bit                    armed     [SLOTS];
    bit                    is_wall   [SLOTS];
    logic [INTERVAL_W-1:0] period_of [SLOTS];
    logic [INTERVAL_W:0]   count_of  [SLOTS];
    total_t                game_sum  = '0;
    total_t                wall_sum  = '0;
    logic [SPEED_W-1:0]    speed_cfg = SPEED_RESET;
    logic                  pause_cfg = 1'b0;

    // Occupancy as seen by the stimulus generator. Slot occupancy depends only
    // on the order of commands, so it can be tracked at the time of queuing.
    bit gen_busy [SLOTS];

    timer_cmd_t    pending_cmds[$];
    timer_result_t awaited_results[$];

    // Handshakes seen at the last rising edge, read at the falling edge.
    logic cmd_beat_seen = 1'b0;
    logic out_beat_seen = 1'b0;
    logic cfg_beat_seen = 1'b0;

    int items_queued = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int ticks_run    = 0;
    int fires_total  = 0;
    int rejects      = 0;
    int saturations  = 0;

    int  send_gap       = 0;
    int  send_calm      = 0;
    int  recv_wait      = 0;
    int  recv_calm      = 0;
    int  hold_left      = 0;
    bit  long_hold_done = 1'b0;

    // Wait length for one beat: mostly a random gap, with occasional runs
    // of back-to-back beats so that full-rate stretches occur too.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Finds a slot at or above lo whose occupancy matches want_busy, starting
    // the scan at a random point. Any slot in range is returned if none match.
    function automatic int find_slot(input bit want_busy, input int lo);
        int start;
        int s;
        start = $urandom_range(0, SLOTS - lo - 1);
        for (int k = 0; k < SLOTS - lo; k++)
        begin
            s = lo + (start + k) % (SLOTS - lo);
            if (gen_busy[s] == want_busy)
                return s;
        end
        return $urandom_range(lo, SLOTS - 1);
    endfunction

    // Applies one command to the local slot bank and returns the result beat
    // that the block must produce for it.
    function automatic timer_result_t timer_bank_step(input timer_cmd_t c);
        timer_result_t     r;
        logic [31:0]       product;
        logic [STEP_W-1:0] step;
        logic [STEP_W-1:0] inc;
        logic [INTERVAL_W+1:0] sum;
        r = '0;
        if (c.op == CMD_TICK)
        begin
            // Game time advances by the tick scaled in Q8, truncated.
            product = c.us * speed_cfg;
            step = product[SPEED_FRAC +: STEP_W];
            if (!pause_cfg)
                game_sum = game_sum + step;
            wall_sum = wall_sum + c.us;
            ticks_run++;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (armed[i] && (is_wall[i] || !pause_cfg))
                begin
                    inc = is_wall[i] ? c.us : step;
                    sum = count_of[i] + inc;
                    // The add saturates first; the compare and the single
                    // subtraction work on the saturated count.
                    if (sum[INTERVAL_W+1])
                    begin
                        sum = COUNT_CEILING;
                        saturations++;
                    end
                    if (sum[INTERVAL_W:0] > period_of[i])
                    begin
                        sum = sum - period_of[i];
                        r.mask[i] = 1'b1;
                        fires_total++;
                    end
                    count_of[i] = sum[INTERVAL_W:0];
                end
            end
        end
        else if (c.op == CMD_REGISTER)
        begin
            if (armed[c.idx])
            begin
                r.rejected = 1'b1;
                rejects++;
            end
            else
            begin
                armed[c.idx]     = 1'b1;
                is_wall[c.idx]   = c.rt;
                period_of[c.idx] = c.period;
                count_of[c.idx]  = '0;
            end
        end
        else if (c.op == CMD_REMOVE)
        begin
            armed[c.idx] = 1'b0;
        end
        r.game = game_sum;
        r.wall = wall_sum;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t ERROR: %s expected %h, got %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Wide arguments let callers pass raw random words; each field keeps
    // only its own low bits.
    task automatic queue_cmd(input logic [31:0] op, input logic [31:0] us,
                             input logic [31:0] idx, input logic [31:0] period,
                             input logic [31:0] rt);
        timer_cmd_t entry;
        entry = {op[CMD_W-1:0], us[TICK_W-1:0], idx[SLOT_W-1:0],
                 period[INTERVAL_W-1:0], rt[0]};
        pending_cmds = {pending_cmds, entry};
        items_queued++;
        if (op[CMD_W-1:0] == CMD_REGISTER)
            gen_busy[idx[SLOT_W-1:0]] = 1'b1;
        else if (op[CMD_W-1:0] == CMD_REMOVE)
            gen_busy[idx[SLOT_W-1:0]] = 1'b0;
    endtask

    // One configuration beat, held until the block takes it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_beat_seen);
        cfg_valid <= 1'b0;
    endtask

    // Every command yields exactly one result, so the bank is idle once the
    // result count has caught up with the number of commands queued.
    task automatic wait_for_idle();
        while (results_seen != items_queued)
            @(negedge clk);
    endtask

    // Command driver. A beat that is not taken stays on the bus unchanged;
    // after a taken beat the driver waits out the gap drawn for it and then
    // presents the next queued command. The valid is assigned once per edge.
    always @(negedge clk)
    begin : feed_commands
        timer_cmd_t next_cmd;
        logic       holding;
        if (rst_n)
        begin
            holding = in_valid && !cmd_beat_seen;
            if (!holding)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_cmds.size() > 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    cmd          <= next_cmd.op;
                    tick_us      <= next_cmd.us;
                    slot         <= next_cmd.idx;
                    interval_us  <= next_cmd.period;
                    realtime_req <= next_cmd.rt;
                    holding = 1'b1;
                    send_gap = draw_wait(send_calm);
                end
            end
            in_valid <= holding;
        end
    end

    // Result receiver. After each taken result beat it stalls for a random
    // number of cycles. Once in the run, while plenty of commands are still
    // waiting to be sent, it holds off for a long stretch so that the block
    // fills up and has to stall its command input.
    always @(negedge clk)
    begin : drain_results
        if (rst_n)
        begin
            if (out_beat_seen)
                recv_wait = draw_wait(recv_calm);
            if (!long_hold_done && results_seen > 150 && pending_cmds.size() > 30)
            begin
                hold_left = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Monitor. Everything is sampled at the rising edge. Configuration beats
    // update the local settings, result beats are checked against the oldest
    // prediction, and command beats are predicted as they are taken.
    always @(posedge clk)
    begin : watch_ports
        timer_result_t want;
        timer_result_t predicted;
        timer_cmd_t    taken;
        cmd_beat_seen <= in_valid && !in_stall;
        out_beat_seen <= out_valid && !out_stall;
        cfg_beat_seen <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SPEED:
                    begin
                        // Speed writes clamp to the range 0.1 to 10.
                        if (cfg_data < SPEED_MIN)
                            speed_cfg = SPEED_MIN;
                        else if (cfg_data > SPEED_MAX)
                            speed_cfg = SPEED_MAX;
                        else
                            speed_cfg = cfg_data;
                    end
                    CFG_PAUSED:
                        pause_cfg = cfg_data[0];
                    default:
                        ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t ERROR: unexpected result beat, mask %h game %h real %h status %b",
                             $time, fired_mask, game_time_us, real_time_us, status);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("fired_mask", want.mask, fired_mask);
                    compare_field("game_time_us", want.game, game_time_us);
                    compare_field("real_time_us", want.wall, real_time_us);
                    compare_field("status", want.rejected, status);
                end
            end
            if (in_valid && !in_stall)
            begin
                taken = {cmd, tick_us, slot, interval_us, realtime_req};
                predicted = timer_bank_step(taken);
                awaited_results = {awaited_results, predicted};
            end
        end
    end

    initial
    begin : run_stimulus
        timer_cmd_t            c;
        int                    pick;
        int                    sub;
        int                    count;
        bit                    saturating;
        logic [CFG_DATA_W-1:0] speed_word;
        logic [CFG_DATA_W-1:0] pause_word;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed list under the reset settings (speed 1.0, running).
        // A tick on an empty bank, with no time and with the largest time.
        queue_cmd(CMD_TICK, 0, $urandom, $urandom, $urandom);
        queue_cmd(CMD_TICK, 32'hFFFFF, $urandom, $urandom, $urandom);
        // Removing a slot that was never filled, then the unused code.
        queue_cmd(CMD_REMOVE, $urandom, 5, $urandom, $urandom);
        queue_cmd(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
        // A zero-period real-time slot and a game-time slot at the largest
        // period, then a second register on a busy slot, which is refused.
        queue_cmd(CMD_REGISTER, $urandom, 0, 0, 1);
        queue_cmd(CMD_REGISTER, $urandom, 15, 32'hFFFF_FFFF, 0);
        queue_cmd(CMD_REGISTER, $urandom, 0, 77, 0);
        queue_cmd(CMD_REGISTER, $urandom, 7, 1000, 0);
        queue_cmd(CMD_REGISTER, $urandom, 8, 32'h8000_0000, 1);
        // With no elapsed time a zero-period slot has a zero count and stays
        // quiet; one microsecond makes it fire.
        queue_cmd(CMD_TICK, 0, $urandom, $urandom, $urandom);
        queue_cmd(CMD_TICK, 1, $urandom, $urandom, $urandom);
        queue_cmd(CMD_TICK, 1001, $urandom, $urandom, $urandom);
        queue_cmd(CMD_TICK, 32'hFFFFF, $urandom, $urandom, $urandom);
        // Refill a removed slot; its count must start from zero again.
        queue_cmd(CMD_REMOVE, $urandom, 7, $urandom, $urandom);
        queue_cmd(CMD_TICK, 500, $urandom, $urandom, $urandom);
        queue_cmd(CMD_REGISTER, $urandom, 7, 3, 1);
        queue_cmd(CMD_TICK, 4, $urandom, $urandom, $urandom);
        queue_cmd(CMD_TICK, 3, $urandom, $urandom, $urandom);
        queue_cmd(CMD_REMOVE, $urandom, 15, $urandom, $urandom);
        queue_cmd(CMD_REGISTER, $urandom, 15, 0, 0);
        queue_cmd(CMD_TICK, 1, $urandom, $urandom, $urandom);
        queue_cmd(CMD_UNUSED, 32'hFFFFF, 15, 32'hFFFF_FFFF, 1);
        wait_for_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            saturating = (ph == SATURATE_PHASE);
            // Speed values include both clamp limits, values beyond each
            // limit and a random word; the pause register only looks at bit 0.
            case (ph)
                0:       begin speed_word = 12'h000; pause_word = 12'h000; end
                1:       begin speed_word = 12'hFFF; pause_word = 12'h001; end
                2:       begin speed_word = 12'd2560; pause_word = 12'hFFE; end
                3:       begin speed_word = $urandom; pause_word = 12'hFFF; end
                4:       begin speed_word = 12'd25; pause_word = 12'h000; end
                5:       begin speed_word = 12'd2561; pause_word = 12'h000; end
                default: begin speed_word = 12'd26; pause_word = 12'h001; end
            endcase
            write_register(CFG_SPEED, speed_word);
            write_register(CFG_PAUSED, pause_word);
            // Writes to the unused indexes must leave the settings alone.
            write_register((ph % 2) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);

            if (saturating)
            begin
                // Park three game-time slots in the low indexes: one with a
                // zero period whose count grows by a full step every tick
                // until it saturates, one just above zero, one at the top.
                for (int s = 0; s < 3; s++)
                    queue_cmd(CMD_REMOVE, $urandom, s, $urandom, $urandom);
                queue_cmd(CMD_REGISTER, $urandom, 0, 0, 0);
                queue_cmd(CMD_REGISTER, $urandom, 1, 7, 0);
                queue_cmd(CMD_REGISTER, $urandom, 2, 32'hFFFF_FFFF, 0);
            end

            count = saturating ? SATURATE_ITEMS : PHASE_ITEMS;
            for (int n = 0; n < count; n++)
            begin
                c.op     = CMD_TICK;
                c.us     = $urandom;
                c.idx    = $urandom;
                c.period = $urandom;
                c.rt     = $urandom;
                pick = $urandom_range(0, 99);
                if (saturating)
                begin
                    // Nearly all ticks are close to the largest value; the
                    // rest churn the upper slots without touching the parked ones.
                    if (pick < 96)
                    begin
                        c.us = $urandom_range(20'hF8000, 20'hFFFFF);
                    end
                    else
                    begin
                        c.idx = find_slot($urandom_range(0, 1), 4);
                        c.op = gen_busy[c.idx] ? CMD_REMOVE : CMD_REGISTER;
                        c.period = $urandom_range(0, 50000000);
                    end
                end
                else if (pick < 55)
                begin
                    sub = $urandom_range(0, 9);
                    if (sub == 0)
                        c.us = '0;
                    else if (sub == 1)
                        c.us = '1;
                    else if (sub < 6)
                        c.us = $urandom_range(0, 3000);
                    else if (sub < 9)
                        c.us = $urandom_range(0, 200000);
                end
                else if (pick < 77)
                begin
                    c.op = CMD_REGISTER;
                    if ($urandom_range(0, 4) != 0)
                        c.idx = find_slot(1'b0, 0);
                    sub = $urandom_range(0, 19);
                    if (sub < 2)
                        c.period = '0;
                    else if (sub == 2)
                        c.period = '1;
                    else if (sub < 13)
                        c.period = $urandom_range(0, 5000);
                    else if (sub < 18)
                        c.period = $urandom_range(5000, 400000);
                end
                else if (pick < 95)
                begin
                    c.op = CMD_REMOVE;
                    if ($urandom_range(0, 3) != 0)
                        c.idx = find_slot(1'b1, 0);
                end
                else
                begin
                    c.op = CMD_UNUSED;
                end
                queue_cmd(c.op, c.us, c.idx, c.period, c.rt);
            end
            // The sender stays quiet until every result of the phase is in.
            wait_for_idle();
        end

        // A tick walks the whole slot memory; allow that much time for a
        // stray result beat to show up.
        repeat (SLOTS + 8) @(negedge clk);

        $display("Covered %0d commands (%0d ticks) across %0d speed and pause settings.",
                 items_queued, ticks_run, NUM_PHASES + 1);
        $display("Slots fired %0d times, %0d registers were refused, counts saturated %0d times.",
                 fires_total, rejects, saturations);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog, sized from the slowest legal run with a wide margin.
    initial
    begin : watchdog
        #5000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
